// ----- design/bba_pkg.sv -----
// bba_pkg: shared constants, codes and controller/datapath bundles
// for the bitmap block allocator; no dependencies
package bba_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 4096;
  localparam int unsigned WORD_W         = 256;
  localparam int unsigned OFF_W          = $clog2(WORD_W);
  localparam int unsigned GRP_W          = 16;
  localparam int unsigned GRP_N          = WORD_W / GRP_W;
  localparam int unsigned GRP_AW         = $clog2(GRP_N);
  localparam int unsigned GB_AW          = $clog2(GRP_W);
  localparam int unsigned CFG_W          = 13;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);
  localparam int unsigned BLK_NUM_W      = 12;
  localparam int unsigned STATUS_W       = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_OUT_OF_BLOCKS = 2'd1,
    ST_FREE_FREE     = 2'd2,
    ST_RANGE         = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_e;

  typedef struct packed {
    logic    load;
    logic    issue;
    logic    wr;
    logic    res_ld;
    status_e res_status;
    logic    out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic found;
    logic last;
    logic in_range;
    logic bit_set;
  } dp_sts_t;

endpackage

// ----- design/bba_req_if.sv -----
// bba_req_if: request channel of the allocator (valid/ready plus payload)
// depends on bba_pkg
interface bba_req_if;
  import bba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [BLK_NUM_W-1:0] block_to_free;

  modport source (output valid, func, block_to_free, input ready);
  modport sink (input valid, func, block_to_free, output ready);
endinterface

// ----- design/bba_rsp_if.sv -----
// bba_rsp_if: response channel of the allocator (valid/ready plus payload)
// depends on bba_pkg
interface bba_rsp_if;
  import bba_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [BLK_NUM_W-1:0] block_number;
  logic [STATUS_W-1:0]  status;

  modport source (output valid, block_number, status, input ready);
  modport sink (input valid, block_number, status, output ready);
endinterface

// ----- design/bba_datapath.sv -----
// bba_datapath: in-use bitmap memory, row scan with first-free search,
// count register and result/output registers; depends on bba_pkg
module bba_datapath #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bba_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           req_func_i,
  input  logic [bba_pkg::BLK_NUM_W-1:0]  req_block_i,
  input  bba_pkg::dp_cmd_t               cmd_i,
  output bba_pkg::dp_sts_t               sts_o,
  output logic [bba_pkg::BLK_NUM_W-1:0]  rsp_block_o,
  output logic [bba_pkg::STATUS_W-1:0]   rsp_status_o
);
  import bba_pkg::*;

  localparam int unsigned ROWS   = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NUM_W  = ROW_AW + OFF_W;
  localparam int unsigned CNT_W  = NUM_W + 1;
  localparam int unsigned CMP_W  = (CNT_W > BLK_NUM_W) ? CNT_W : BLK_NUM_W;
  localparam int unsigned CL_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned NUM_X  = (NUM_W > BLK_NUM_W) ? NUM_W : BLK_NUM_W;

  logic [WORD_W-1:0]    mem_q [ROWS];
  logic [ROWS-1:0]      row_vld_q;
  logic [CFG_W-1:0]     cfg_q;
  func_e                func_q;
  logic [BLK_NUM_W-1:0] blk_q;
  logic [ROW_AW-1:0]    row_q;
  logic [ROW_AW-1:0]    rd_row_q;
  logic [WORD_W-1:0]    rdata_q;
  logic                 rd_vld_q;
  logic [WORD_W-1:0]    mask_q;
  logic [WORD_W-1:0]    mask_d;
  logic [BLK_NUM_W-1:0] res_num_q;
  status_e              res_st_q;
  logic [BLK_NUM_W-1:0] out_num_q;
  status_e              out_st_q;

  logic [CL_W-1:0]      cfg_x;
  logic [CL_W-1:0]      max_x;
  logic [CL_W-1:0]      cnt_cl;
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     base_issue;
  logic [CNT_W-1:0]     base_chk;
  logic [WORD_W-1:0]    word;
  logic [WORD_W-1:0]    free_vec;
  logic [GRP_N-1:0]     grp_any;
  logic [GRP_AW-1:0]    grp_sel;
  logic [GRP_W-1:0]     grp_bits;
  logic [GB_AW-1:0]     bit_sel;
  logic [OFF_W-1:0]     pos;
  logic [NUM_W-1:0]     alloc_num;
  logic [NUM_X-1:0]     alloc_num_x;
  logic [CMP_W-1:0]     blk_x;
  logic [CMP_W-1:0]     req_x;
  logic [OFF_W-1:0]     blk_off;
  logic [WORD_W-1:0]    onehot;
  logic [WORD_W-1:0]    wr_data;

  // managed count, clamped to capacity
  assign cfg_x  = CL_W'(cfg_q);
  assign max_x  = CL_W'(MAX_BLOCKS);
  assign cnt_cl = (cfg_x > max_x) ? max_x : cfg_x;
  assign cnt    = cnt_cl[CNT_W-1:0];

  // eligibility mask of the row being read
  assign base_issue = {(ROW_AW + 1)'(row_q) + (ROW_AW + 1)'(1), {OFF_W{1'b0}}};
  assign mask_d     = (cnt >= base_issue) ? '1 : ~({WORD_W{1'b1}} << cnt[OFF_W-1:0]);
  assign base_chk   = {(ROW_AW + 1)'(rd_row_q) + (ROW_AW + 1)'(1), {OFF_W{1'b0}}};

  assign word     = rd_vld_q ? rdata_q : '0;
  assign free_vec = ~word & mask_q;

  // two-level first-free search
  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      grp_any[g] = |free_vec[g*GRP_W +: GRP_W];
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GRP_AW'(g);
      end
    end
  end

  assign grp_bits = free_vec[grp_sel*GRP_W +: GRP_W];

  always_comb begin
    bit_sel = '0;
    for (int b = GRP_W - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = GB_AW'(b);
      end
    end
  end

  assign pos         = {grp_sel, bit_sel};
  assign alloc_num   = {rd_row_q, pos};
  assign alloc_num_x = NUM_X'(alloc_num);

  assign blk_x   = CMP_W'(blk_q);
  assign req_x   = CMP_W'(req_block_i);
  assign blk_off = blk_x[OFF_W-1:0];

  assign onehot  = {{(WORD_W - 1){1'b0}}, 1'b1} << ((func_q == FUNC_FREE) ? blk_off : pos);
  assign wr_data = (func_q == FUNC_FREE) ? (word & ~onehot) : (word | onehot);

  assign sts_o.found    = |grp_any;
  assign sts_o.last     = (cnt <= base_chk);
  assign sts_o.in_range = (blk_x < CMP_W'(cnt));
  assign sts_o.bit_set  = word[blk_off];

  assign rsp_block_o  = out_num_q;
  assign rsp_status_o = out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CFG_RESET;
      row_vld_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.wr) begin
        row_vld_q[rd_row_q] <= 1'b1;
      end
    end
  end

  // bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[rd_row_q] <= wr_data;
    end
    if (cmd_i.issue) begin
      rdata_q <= mem_q[row_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_e'(req_func_i);
      blk_q  <= req_block_i;
      row_q  <= req_func_i ? req_x[NUM_W-1:OFF_W] : '0;
    end else if (cmd_i.issue) begin
      row_q <= row_q + ROW_AW'(1);
    end
    if (cmd_i.issue) begin
      rd_row_q <= row_q;
      rd_vld_q <= row_vld_q[row_q];
      mask_q   <= mask_d;
    end
    if (cmd_i.res_ld) begin
      res_st_q <= cmd_i.res_status;
      if (func_q == FUNC_FREE) begin
        res_num_q <= blk_q;
      end else if (cmd_i.res_status == ST_OK) begin
        res_num_q <= alloc_num_x[BLK_NUM_W-1:0];
      end else begin
        res_num_q <= '0;
      end
    end
    if (cmd_i.out_ld) begin
      out_num_q <= res_num_q;
      out_st_q  <= res_st_q;
    end
  end

endmodule

// ----- design/bba_ctrl.sv -----
// bba_ctrl: request sequencer for allocate scans and frees, and the
// response valid flag; depends on bba_pkg
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_func_i,
  output logic             req_ready_o,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  input  bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_A_RD   = 6'b000010,
    S_A_SCAN = 6'b000100,
    S_F_RD   = 6'b001000,
    S_F_CHK  = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.res_status  = ST_OK;
    out_valid_d       = out_valid_q && !rsp_ready_i;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (func_e'(req_func_i) == FUNC_FREE) ? S_F_RD : S_A_RD;
        end
      end
      S_A_RD: begin
        cmd_o.issue = 1'b1;
        state_d     = S_A_SCAN;
      end
      S_A_SCAN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.found) begin
          cmd_o.wr     = 1'b1;
          cmd_o.res_ld = 1'b1;
          state_d      = S_DONE;
        end else if (sts_i.last) begin
          cmd_o.res_ld     = 1'b1;
          cmd_o.res_status = ST_OUT_OF_BLOCKS;
          state_d          = S_DONE;
        end
      end
      S_F_RD: begin
        cmd_o.issue = 1'b1;
        state_d     = S_F_CHK;
      end
      S_F_CHK: begin
        cmd_o.res_ld = 1'b1;
        state_d      = S_DONE;
        if (!sts_i.in_range) begin
          cmd_o.res_status = ST_RANGE;
        end else if (!sts_i.bit_set) begin
          cmd_o.res_status = ST_FREE_FREE;
        end else begin
          cmd_o.wr = 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_q || rsp_ready_i) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/bitmap_block_allocator.sv -----
// bitmap_block_allocator: first-fit block allocator over a one-bit-per-block map
// depends on bba_pkg, bba_req_if, bba_rsp_if, bba_ctrl, bba_datapath
//
// The in-use map lives in a memory of 256-bit rows, one read port, and every
// row reads as all free until it is first written, so the block is usable
// right after reset. One request is handled at a time. An allocate reads the
// map a row per cycle from block zero and stops at the first row that holds
// a free block, or at the row that holds the end of the managed count; a free
// reads and checks the one row that holds its block. A finished response waits
// in an output register, so the next request is taken while it is still pending.
module bitmap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata_i,
  bba_req_if.sink                   req_i,
  bba_rsp_if.source                 rsp_o
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_func_i  (req_i.func),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_func_i   (req_i.func),
    .req_block_i  (req_i.block_to_free),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_block_o  (rsp_o.block_number),
    .rsp_status_o (rsp_o.status)
  );

  // a new response never overwrites one that is still stalled
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_ld |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response register overwritten while stalled");

  // one transaction in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // out-of-blocks responses carry block zero
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status == ST_OUT_OF_BLOCKS) |-> (rsp_o.block_number == '0))
    else $error("out-of-blocks response with nonzero block number");

endmodule
